// File: src/gvc_pkg.sv
`timescale 1ns / 1ps

package gvc_pkg;

    localparam int VERTEX_CAPACITY = 1024;
    localparam int VIDX_W          = 10;
    localparam int CNT_W           = 11;
    localparam int MAX_COLORS      = 16;
    localparam int COLOR_W         = 4;
    localparam int CUSED_W         = 5;

    localparam logic [CNT_W-1:0]   VERTEX_COUNT_RESET = 11'd1024;
    localparam logic [COLOR_W-1:0] COLOR_TOP          = 4'd15;

    typedef struct packed {
        logic [VIDX_W-1:0] neighbor_index;
        logic              has_neighbor;
        logic              last_of_vertex;
    } t_in_beat;

    typedef struct packed {
        logic [VIDX_W-1:0]  vertex_id;
        logic [COLOR_W-1:0] assigned_color;
        logic [CUSED_W-1:0] colors_used;
        logic               graph_done;
        logic               color_overflow;
        logic               range_error;
    } t_out_beat;

endpackage

// File: src/greedy_vertex_coloring_core.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake               | Beat contents
// ----------+-----------+-------------------------+-------------------------------
// in        | input     | i_in_valid / o_in_ready | gvc_pkg::t_in_beat, one neighbor
// out       | output    | o_out_valid/ i_out_ready| gvc_pkg::t_out_beat, one vertex
// cfg       | input     | i_cfg_valid/ o_cfg_ready| vertex_count, 11 bits
//
// The core takes one input beat per cycle. Each beat reads the color store
// once, and the store's registered read data sets the two-stage pipeline:
// the result of a vertex-ending beat is registered in the output register
// as that beat leaves the second stage, and a ready consumer takes it there.
// Reset is synchronous and clears only control state; the color store needs
// no clearing pass because only entries written earlier in the same graph are
// read. When the output register is full and not taken, a vertex-ending beat
// in the second stage holds and the input side stalls until it moves on.
module greedy_vertex_coloring_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gvc_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gvc_pkg::t_out_beat  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [gvc_pkg::CNT_W-1:0] i_cfg_data
);

    import gvc_pkg::*;

    // Configuration register and the clamped vertex count derived from it.
    logic [CNT_W-1:0] r_vertex_count;
    logic [CNT_W-1:0] eff_count;

    // Front-end state, advanced when a vertex-ending beat is accepted.
    logic [VIDX_W-1:0] r_cur_vertex;
    logic [VIDX_W-1:0] n_cur_vertex;

    // Second pipeline stage: holds the beat whose color-store read is in flight.
    logic               r_s1_valid;
    logic               r_s1_last;
    logic               r_s1_hit;
    logic               r_s1_rerr;
    logic               r_s1_done;
    logic [VIDX_W-1:0]  r_s1_vertex;
    logic               r_s1_fwd;
    logic [COLOR_W-1:0] r_s1_fwd_color;

    // Per-vertex and per-graph accumulators, maintained in the second stage.
    logic [MAX_COLORS-1:0] r_used;
    logic                  r_pend_rerr;
    logic [CUSED_W-1:0]    r_max_plus_one;

    // Output register.
    logic      r_out_valid;
    t_out_beat r_out_data;

    logic               in_fire;
    logic               s1_stall;
    logic               s1_adv;
    logic               s1_emit;
    logic               nb_in_range;
    logic               nb_lower;
    logic               nb_hit;
    logic               s0_done;
    logic               s0_fwd;
    logic [COLOR_W-1:0] ram_rdata;
    logic [COLOR_W-1:0] s1_nb_color;
    logic [MAX_COLORS-1:0] used_next;
    logic [COLOR_W-1:0] pick_color;
    logic               pick_overflow;
    logic [CUSED_W-1:0] color_plus_one;
    logic [CUSED_W-1:0] max_next;

    // The count register is only to be written while the core is idle; the core itself does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VERTEX_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // Clamp to 1 .. VERTEX_CAPACITY.
    always_comb begin
        eff_count = r_vertex_count;
        if (r_vertex_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (r_vertex_count > CNT_W'(VERTEX_CAPACITY)) begin
            eff_count = CNT_W'(VERTEX_CAPACITY);
        end
    end

    // A vertex-ending beat in the second stage can only leave when the output
    // register is free or being emptied in this cycle.
    assign s1_stall   = r_s1_valid && r_s1_last && r_out_valid && !i_out_ready;
    assign s1_adv     = r_s1_valid && !s1_stall;
    assign s1_emit    = s1_adv && r_s1_last;
    assign o_in_ready = !s1_stall;
    assign in_fire    = i_in_valid && o_in_ready;

    // First stage: classify the neighbor and start the color-store read.
    assign nb_in_range = {1'b0, i_in_data.neighbor_index} < eff_count;
    assign nb_lower    = i_in_data.neighbor_index < r_cur_vertex;
    assign nb_hit      = i_in_data.has_neighbor && nb_in_range && nb_lower;
    assign s0_done     = ({1'b0, r_cur_vertex} + CNT_W'(1)) >= eff_count;

    // The vertex finishing in the second stage is written in the same cycle
    // that the next vertex may read it; the store returns old data then, so
    // the freshly picked color is carried forward instead.
    assign s0_fwd = s1_emit && (i_in_data.neighbor_index == r_s1_vertex);

    always_comb begin
        n_cur_vertex = r_cur_vertex;
        if (in_fire && i_in_data.last_of_vertex) begin
            n_cur_vertex = s0_done ? '0 : r_cur_vertex + VIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vertex <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_cur_vertex <= n_cur_vertex;
            if (!s1_stall) begin
                r_s1_valid <= in_fire;
            end
        end
    end

    // Payload of the second stage needs no reset; it is qualified by r_s1_valid.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_last      <= i_in_data.last_of_vertex;
            r_s1_hit       <= nb_hit;
            r_s1_rerr      <= i_in_data.has_neighbor && !nb_in_range;
            r_s1_done      <= s0_done;
            r_s1_vertex    <= r_cur_vertex;
            r_s1_fwd       <= s0_fwd;
            r_s1_fwd_color <= pick_color;
        end
    end

    gvc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (VERTEX_CAPACITY)
    ) u_color_store (
        .i_clk   (i_clk),
        .i_we    (s1_emit),
        .i_waddr (r_s1_vertex),
        .i_wdata (pick_color),
        .i_re    (in_fire),
        .i_raddr (i_in_data.neighbor_index),
        .o_rdata (ram_rdata)
    );

    // Second stage: merge the neighbor's color into the bitmap and, at the
    // end of a vertex, pick the lowest free color.
    assign s1_nb_color = r_s1_fwd ? r_s1_fwd_color : ram_rdata;

    always_comb begin
        used_next = r_used;
        if (r_s1_hit) begin
            used_next = r_used | (MAX_COLORS'(1) << s1_nb_color);
        end
    end

    // Priority search from the top down so the lowest free color wins.
    always_comb begin
        pick_color    = COLOR_TOP;
        pick_overflow = &used_next;
        for (int c = MAX_COLORS - 1; c >= 0; c--) begin
            if (!used_next[c]) begin
                pick_color = COLOR_W'(c);
            end
        end
    end

    assign color_plus_one = {1'b0, pick_color} + CUSED_W'(1);
    assign max_next = (color_plus_one > r_max_plus_one) ? color_plus_one : r_max_plus_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used         <= '0;
            r_pend_rerr    <= 1'b0;
            r_max_plus_one <= '0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                r_used         <= '0;
                r_pend_rerr    <= 1'b0;
                r_max_plus_one <= r_s1_done ? '0 : max_next;
            end else begin
                r_used      <= used_next;
                r_pend_rerr <= r_pend_rerr || r_s1_rerr;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_out_data.vertex_id      <= r_s1_vertex;
            r_out_data.assigned_color <= pick_color;
            r_out_data.colors_used    <= max_next;
            r_out_data.graph_done     <= r_s1_done;
            r_out_data.color_overflow <= pick_overflow;
            r_out_data.range_error    <= r_pend_rerr || r_s1_rerr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: src/gvc_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written returns the old contents.
module gvc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/gvc_checker.sv
`timescale 1ns / 1ps

module gvc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input gvc_pkg::t_out_beat  o_out_data
);

    import gvc_pkg::*;

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // The running color count always covers the color just assigned.
    a_count_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out_data.assigned_color} < o_out_data.colors_used))
        else $error("colors_used below assigned color plus one");

    // A saturated color is always the top color.
    a_overflow_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.color_overflow |-> o_out_data.assigned_color == COLOR_TOP)
        else $error("overflow without the top color");

    // The last vertex slot always ends the graph.
    a_last_slot_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.vertex_id == VIDX_W'(VERTEX_CAPACITY - 1))
        |-> o_out_data.graph_done)
        else $error("last vertex slot did not end the graph");

endmodule

bind greedy_vertex_coloring_core gvc_checker u_gvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gvc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    // After the last expected result, the wait also covers beats still in
    // flight that produce no result.
    localparam int SETTLE_CYCLES = 6;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in_beat          in_beat   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_beat         out_beat;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data  = '0;

    greedy_vertex_coloring_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Coloring state as the block should hold it.
    logic [COLOR_W-1:0]    color_table [VERTEX_CAPACITY];
    logic [MAX_COLORS-1:0] used_mask       = '0;
    int                    cur_vertex      = 0;
    int                    max_color_p1    = 0;
    logic                  pend_range_err  = 1'b0;
    logic [CNT_W-1:0]      vertex_count_reg = VERTEX_COUNT_RESET;

    t_out_beat pending_colorings [$];
    int        mismatches = 0;
    int        beats_sent = 0;
    int        burst_left = 0;
    bit        gaps_on    = 1'b1;
    int        cycles     = 0;

    function automatic int effective_count();
        if (vertex_count_reg == 0) return 1;
        if (vertex_count_reg > VERTEX_CAPACITY) return VERTEX_CAPACITY;
        return int'(vertex_count_reg);
    endfunction

    function automatic t_in_beat mk_beat(input int idx, input bit has, input bit last);
        t_in_beat b;
        b.neighbor_index = idx[VIDX_W-1:0];
        b.has_neighbor   = has;
        b.last_of_vertex = last;
        return b;
    endfunction

    // Update the coloring state for one accepted beat and queue the result
    // that a vertex-ending beat must produce.
    task automatic predict_coloring(input t_in_beat beat);
        int        nb;
        int        color;
        bit        found;
        bit        done;
        t_out_beat res;
        nb    = int'(beat.neighbor_index);
        color = MAX_COLORS - 1;
        found = 1'b0;
        if (beat.has_neighbor) begin
            if (nb >= effective_count()) begin
                pend_range_err = 1'b1;
            end else if (nb < cur_vertex) begin
                used_mask[color_table[nb]] = 1'b1;
            end
        end
        if (beat.last_of_vertex) begin
            for (int c = 0; c < MAX_COLORS; c++) begin
                if (!found && !used_mask[c]) begin
                    color = c;
                    found = 1'b1;
                end
            end
            color_table[cur_vertex] = color[COLOR_W-1:0];
            if (color + 1 > max_color_p1) max_color_p1 = color + 1;
            done = (cur_vertex + 1 >= effective_count());
            res.vertex_id      = cur_vertex[VIDX_W-1:0];
            res.assigned_color = color[COLOR_W-1:0];
            res.colors_used    = max_color_p1[CUSED_W-1:0];
            res.graph_done     = done;
            res.color_overflow = !found;
            res.range_error    = pend_range_err;
            pending_colorings.insert(pending_colorings.size(), res);
            used_mask      = '0;
            pend_range_err = 1'b0;
            if (done) begin
                cur_vertex   = 0;
                max_color_p1 = 0;
            end else begin
                cur_vertex = cur_vertex + 1;
            end
        end
    endtask

    // Send one beat. The sender works in bursts; between bursts valid may
    // drop for a random gap.
    task automatic send_beat(input t_in_beat beat);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
        predict_coloring(beat);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_colorings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        vertex_count_reg = value;
        @(negedge clk);
        cfg_valid  <= 1'b0;
        burst_left = 0;
    endtask

    // Mostly recent lower neighbors so that colors climb, plus higher,
    // self, out-of-range and empty beats as noise.
    function automatic t_in_beat pick_neighbor();
        t_in_beat b;
        int       r;
        int       eff;
        int       lo;
        int       idx;
        eff = effective_count();
        r   = $urandom_range(0, 99);
        idx = $urandom_range(0, VERTEX_CAPACITY - 1);
        b   = mk_beat(0, 1'b1, 1'b0);
        if (r < 65) begin
            if (cur_vertex > 0) begin
                lo  = (cur_vertex > 16) ? cur_vertex - 16 : 0;
                idx = $urandom_range(lo, cur_vertex - 1);
            end
        end else if (r < 75) begin
            // Keep the fully random index.
        end else if (r < 85) begin
            b.has_neighbor = 1'b0;
        end else if (r < 93) begin
            if (cur_vertex < eff) idx = $urandom_range(cur_vertex, eff - 1);
        end else if (eff < VERTEX_CAPACITY) begin
            idx = $urandom_range(eff, VERTEX_CAPACITY - 1);
        end
        b.neighbor_index = idx[VIDX_W-1:0];
        return b;
    endfunction

    task automatic send_random_vertex(input int max_beats);
        int       n;
        t_in_beat b;
        n = $urandom_range(1, max_beats);
        for (int k = 0; k < n; k++) begin
            b = pick_neighbor();
            b.last_of_vertex = (k == n - 1);
            send_beat(b);
        end
    endtask

    // Self neighbor, higher neighbor, empty beat, extreme and alternating
    // index patterns, all at the count left by reset.
    task automatic test_directed();
        send_beat(mk_beat(0, 1'b1, 1'b0));
        send_beat(mk_beat(1023, 1'b1, 1'b0));
        send_beat(mk_beat(5, 1'b0, 1'b1));
        send_beat(mk_beat(0, 1'b1, 1'b1));
        send_beat(mk_beat(0, 1'b1, 1'b0));
        send_beat(mk_beat(1, 1'b1, 1'b1));
        send_beat(mk_beat(1, 1'b1, 1'b0));
        send_beat(mk_beat(2, 1'b1, 1'b0));
        send_beat(mk_beat('h155, 1'b1, 1'b0));
        send_beat(mk_beat('h2AA, 1'b0, 1'b1));
        send_beat(mk_beat(3, 1'b1, 1'b1));
    endtask

    // A count of zero acts as one and a count past capacity acts as the
    // capacity; the first write also cuts the open graph short.
    task automatic test_count_clamp();
        write_vertex_count('0);
        send_beat(mk_beat(3, 1'b1, 1'b0));
        send_beat(mk_beat(1023, 1'b1, 1'b1));
        send_beat(mk_beat(0, 1'b1, 1'b1));
        write_vertex_count('1);
        send_beat(mk_beat(0, 1'b1, 1'b1));
        send_beat(mk_beat(0, 1'b1, 1'b1));
    endtask

    task automatic test_count_lowered();
        write_vertex_count(11'd40);
        send_beat(mk_beat(1, 1'b1, 1'b1));
        send_beat(mk_beat(2, 1'b1, 1'b0));
        send_beat(mk_beat(0, 1'b1, 1'b1));
        send_beat(mk_beat(39, 1'b1, 1'b0));
        send_beat(mk_beat(40, 1'b1, 1'b1));
        // The open graph is now past the new count, so the next vertex ends it.
        write_vertex_count(11'd3);
        send_beat(mk_beat(4, 1'b1, 1'b1));
        send_beat(mk_beat(0, 1'b1, 1'b1));
    endtask

    // Each vertex of a clique sees every lower vertex in shuffled order, so
    // vertex 16 and above find all colors taken.
    task automatic test_color_overflow();
        int order [$];
        int j;
        int tmp;
        write_vertex_count(11'd1);
        send_beat(mk_beat(0, 1'b0, 1'b1));
        write_vertex_count(11'd18);
        for (int rep = 0; rep < 2; rep++) begin
            for (int v = 0; v < 18; v++) begin
                order.delete();
                for (int k = 0; k < v; k++) order.insert(order.size(), k);
                if ($urandom_range(0, 3) == 0)
                    order.insert(order.size(), int'($urandom_range(18, 1023)));
                for (int k = order.size() - 1; k > 0; k--) begin
                    j        = $urandom_range(0, k);
                    tmp      = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
                if (order.size() == 0) begin
                    send_beat(mk_beat($urandom_range(0, 1023), 1'b0, 1'b1));
                end else begin
                    for (int k = 0; k < order.size(); k++)
                        send_beat(mk_beat(order[k], 1'b1, k == order.size() - 1));
                end
            end
        end
    endtask

    task automatic test_random_graphs();
        logic [CNT_W-1:0] count;
        int               start;
        for (int phase = 0; phase < 6; phase++) begin
            count   = CNT_W'($urandom_range(1, 48));
            write_vertex_count(count);
            gaps_on = (phase % 3 != 2);
            start   = beats_sent;
            while (beats_sent - start < 55) send_random_vertex(10);
        end
    endtask

    // One graph at full capacity, so the vertex index runs to its top value.
    // Every beat ends its vertex, so results follow each other closely.
    task automatic test_full_graph();
        write_vertex_count(11'd1);
        send_beat(mk_beat(0, 1'b0, 1'b1));
        write_vertex_count(VERTEX_COUNT_RESET);
        for (int v = 0; v < VERTEX_CAPACITY; v++) begin
            gaps_on = (v >= VERTEX_CAPACITY / 2);
            send_random_vertex(1);
        end
    endtask

    // Receiver: switches between always ready, coin-flip ready and ready one
    // cycle in four, each mode held for a random stretch.
    int rcv_mode = 0;
    int rcv_left = 0;
    int rcv_tick = 0;

    always @(negedge clk) begin
        if (rcv_left == 0) begin
            rcv_mode = $urandom_range(0, 2);
            rcv_left = $urandom_range(30, 200);
        end else begin
            rcv_left--;
        end
        rcv_tick++;
        case (rcv_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= (rcv_tick % 4 == 0);
        endcase
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin : take_result
            t_out_beat want;
            if (pending_colorings.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got %p",
                         $time, out_beat);
                mismatches++;
            end else begin
                want = pending_colorings.pop_front();
                check_field("vertex_id", 16'(want.vertex_id), 16'(out_beat.vertex_id));
                check_field("assigned_color", 16'(want.assigned_color),
                            16'(out_beat.assigned_color));
                check_field("colors_used", 16'(want.colors_used),
                            16'(out_beat.colors_used));
                check_field("graph_done", 16'(want.graph_done), 16'(out_beat.graph_done));
                check_field("color_overflow", 16'(want.color_overflow),
                            16'(out_beat.color_overflow));
                check_field("range_error", 16'(want.range_error),
                            16'(out_beat.range_error));
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within the cycle limit", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_count_clamp();
        test_count_lowered();
        test_color_overflow();
        test_random_graphs();
        test_full_graph();
        wait_idle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: greedy_vertex_coloring_core.f
src/gvc_pkg.sv
src/gvc_ram.sv
src/greedy_vertex_coloring_core.sv
src/gvc_checker.sv
test/testbench.sv
